// File: sv/ofgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ofgm_pkg
// Shared types and constants for the optical-flow ground motion block.
// ----------------------------------------------------------------------------
package ofgm_pkg;

  // Stream and configuration port widths.
  localparam int IN_W   = 96;
  localparam int OUT_W  = 168;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_MIN_HEIGHT   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DEF_INTERVAL = 2'd2;

  // Register values after reset.
  localparam logic [15:0] RST_MIN_HEIGHT   = 16'd100;
  localparam logic [7:0]  RST_MIN_INTERVAL = 8'd1;
  localparam logic [7:0]  RST_DEF_INTERVAL = 8'd25;

  // Divider: the dividend magnitude |angle * 1000| fits in 25 bits.
  localparam int DIV_W = 25;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Flow angle scale from per-frame to per-second (ms to s).
  localparam logic signed [MUL_B_W-1:0] FLOW_SCALE = 17'sd1000;

  // Truncation bias for the signed divide by 4096.
  localparam logic [PROD_W-1:0] DIV4096_BIAS = PROD_W'(4095);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ANG,
    ST_DIV_LOAD,
    ST_DIV,
    ST_RATE,
    ST_MUL_H,
    ST_SPD,
    ST_MUL_DT,
    ST_ACC,
    ST_DONE
  } ofgm_state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_ANGLE,
    MSEL_HEIGHT,
    MSEL_DT
  } ofgm_msel_t;

  // Control decoded from the sequencer state.
  typedef struct packed {
    logic       in_ready;
    logic       mul_en;
    ofgm_msel_t msel;
  } ofgm_ctrl_t;

endpackage
`default_nettype wire

// File: sv/optical_flow_ground_motion.sv
// Sequence: per axis of an accepted sample, a 25-step restoring divide and
//   seven other steps run; the result then loads into the output register.
// Flow: a new sample is taken only once the result is loaded; the shared
//   divider and one 32x17 multiplier serve both axes; invalid samples skip to ST_DONE.
// Reset (rst_n low, synchronous): registers return to 100 / 1 / 25, both
//   displacement accumulators clear and no result is pending.
`default_nettype none
// ----------------------------------------------------------------------------
// optical_flow_ground_motion
// Turns an optical-flow sample into gyro-compensated ground velocity and
// integrates it into displacement, using one iterative divider and one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module optical_flow_ground_motion
  import ofgm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0: flow_ok[0], height_ok[1], agl_mm[17:2],
  // interval_ms[25:18], flow_angle_x[41:26], flow_angle_y[57:42],
  // gyro_pitch[75:58], gyro_roll[93:76], zero fill[95:94].
  input  wire logic [IN_W-1:0]   in_tdata,
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // out_tdata from bit 0: motion_ok[0], speed_x[32:1], speed_y[64:33],
  // travel_x[112:65], travel_y[160:113], zero fill[167:161].
  output logic [OUT_W-1:0]       out_tdata
);

  // Input field views.
  logic               in_flow_ok;
  logic               in_height_ok;
  logic [15:0]        in_agl_mm;
  logic [7:0]         in_interval_ms;
  logic signed [15:0] in_flow_angle_x;
  logic signed [15:0] in_flow_angle_y;
  logic signed [17:0] in_gyro_pitch;
  logic signed [17:0] in_gyro_roll;

  assign in_flow_ok      = in_tdata[0];
  assign in_height_ok    = in_tdata[1];
  assign in_agl_mm       = in_tdata[17:2];
  assign in_interval_ms  = in_tdata[25:18];
  assign in_flow_angle_x = in_tdata[41:26];
  assign in_flow_angle_y = in_tdata[57:42];
  assign in_gyro_pitch   = in_tdata[75:58];
  assign in_gyro_roll    = in_tdata[93:76];

  // Registers.
  ofgm_state_t        state_r, state_nxt;
  ofgm_ctrl_t         ctrl;
  logic [15:0]        min_height_r;
  logic [7:0]         min_interval_r;
  logic [7:0]         def_interval_r;
  logic [47:0]        acc_x_r, acc_y_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               ok_r;
  logic               axis_r;
  logic [15:0]        h_r;
  logic [7:0]         dt_r;
  logic signed [15:0] ang_x_r, ang_y_r;
  logic signed [17:0] gyr_p_r, gyr_r_r;
  logic signed [PROD_W-1:0] prod_r;
  logic               neg_r;
  logic [DIV_W-1:0]   quo_r;
  logic [7:0]         rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [26:0] rate_r;
  logic signed [31:0] spd_x_r, spd_y_r;

  logic in_accept;
  logic out_free;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_flow_ok && in_height_ok) ? ST_MUL_ANG : ST_DONE;
        end
      end
      ST_MUL_ANG:  state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_RATE;
        end
      end
      ST_RATE:   state_nxt = ST_MUL_H;
      ST_MUL_H:  state_nxt = ST_SPD;
      ST_SPD:    state_nxt = ST_MUL_DT;
      ST_MUL_DT: state_nxt = ST_ACC;
      ST_ACC:    state_nxt = axis_r ? ST_DONE : ST_MUL_ANG;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctrl = '{in_ready: 1'b0, mul_en: 1'b0, msel: MSEL_ANGLE};
    unique case (state_r)
      ST_IDLE:    ctrl.in_ready = 1'b1;
      ST_MUL_ANG: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_ANGLE;
      end
      ST_MUL_H: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_HEIGHT;
      end
      ST_MUL_DT: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_DT;
      end
      default: ctrl = '{in_ready: 1'b0, mul_en: 1'b0, msel: MSEL_ANGLE};
    endcase
  end

  assign in_tready = ctrl.in_ready;

  // Per-axis operands: x uses flow about y and pitch, y uses flow about x and roll.
  logic signed [15:0] ang_sel;
  logic signed [17:0] gyr_sel;
  logic signed [31:0] spd_sel;

  assign ang_sel = axis_r ? ang_x_r : ang_y_r;
  assign gyr_sel = axis_r ? gyr_r_r : gyr_p_r;
  assign spd_sel = axis_r ? spd_y_r : spd_x_r;

  // Shared multiplier with its operand select.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;

  always_comb begin
    case (ctrl.msel)
      MSEL_ANGLE: begin
        mul_a = {{(MUL_A_W-16){ang_sel[15]}}, ang_sel};
        mul_b = FLOW_SCALE;
      end
      MSEL_HEIGHT: begin
        mul_a = {{(MUL_A_W-27){rate_r[26]}}, rate_r};
        mul_b = {1'b0, h_r};
      end
      MSEL_DT: begin
        mul_a = spd_sel;
        mul_b = {{(MUL_B_W-8){1'b0}}, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Divider step: shift one dividend bit into the remainder and try a subtract.
  logic [8:0] div_trial;
  logic [8:0] div_diff;
  logic       div_ge;

  assign div_trial = {rem_r, quo_r[DIV_W-1]};
  assign div_diff  = div_trial - {1'b0, dt_r};
  assign div_ge    = div_trial >= {1'b0, dt_r};

  // Dividend magnitude from the scaled flow product.
  logic [PROD_W-1:0] prod_abs;
  assign prod_abs = prod_r[PROD_W-1] ? (~prod_r + 1'b1) : prod_r;

  // Signed quotient minus the gyro rate.
  logic signed [25:0] quo_s;
  logic signed [26:0] rate_nxt;

  assign quo_s    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign rate_nxt = {quo_s[25], quo_s} - {{9{gyr_sel[17]}}, gyr_sel};

  // Divide by 4096 rounding toward zero, then saturate to 32 bits.
  logic [PROD_W-1:0] spd_biased;
  logic [36:0]       spd_wide;
  logic signed [31:0] spd_nxt;

  always_comb begin
    spd_biased = prod_r + (prod_r[PROD_W-1] ? DIV4096_BIAS : '0);
    spd_wide   = spd_biased[PROD_W-1:12];
    if (spd_wide[36:31] == {6{spd_wide[36]}}) begin
      spd_nxt = spd_wide[31:0];
    end else if (spd_wide[36]) begin
      spd_nxt = {1'b1, 31'd0};
    end else begin
      spd_nxt = {1'b0, {31{1'b1}}};
    end
  end

  // Clamped height and interval of an accepted sample.
  logic [15:0] h_in;
  logic [7:0]  dt_in;

  always_comb begin
    h_in  = (in_agl_mm < min_height_r) ? min_height_r : in_agl_mm;
    dt_in = (in_interval_ms <= min_interval_r) ? def_interval_r : in_interval_ms;
    if (dt_in == 8'd0) begin
      dt_in = 8'd1;
    end
  end

  // Control state, configuration and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      min_height_r   <= RST_MIN_HEIGHT;
      min_interval_r <= RST_MIN_INTERVAL;
      def_interval_r <= RST_DEF_INTERVAL;
      acc_x_r        <= '0;
      acc_y_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MIN_HEIGHT:   min_height_r   <= cfg_wdata;
          REG_MIN_INTERVAL: min_interval_r <= cfg_wdata[7:0];
          REG_DEF_INTERVAL: def_interval_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (state_r == ST_ACC) begin
        if (axis_r) begin
          acc_y_r <= acc_y_r + prod_r[47:0];
        end else begin
          acc_x_r <= acc_x_r + prod_r[47:0];
        end
      end
      // The output register frees on a result transaction and fills from the sequencer.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ok_r    <= in_flow_ok && in_height_ok;
      axis_r  <= 1'b0;
      h_r     <= h_in;
      dt_r    <= dt_in;
      ang_x_r <= in_flow_angle_x;
      ang_y_r <= in_flow_angle_y;
      gyr_p_r <= in_gyro_pitch;
      gyr_r_r <= in_gyro_roll;
      spd_x_r <= '0;
      spd_y_r <= '0;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    case (state_r)
      ST_DIV_LOAD: begin
        neg_r <= prod_r[PROD_W-1];
        quo_r <= prod_abs[DIV_W-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_ge ? div_diff[7:0] : div_trial[7:0];
        quo_r <= {quo_r[DIV_W-2:0], div_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_RATE: rate_r <= rate_nxt;
      ST_SPD: begin
        if (axis_r) begin
          spd_y_r <= spd_nxt;
        end else begin
          spd_x_r <= spd_nxt;
        end
      end
      ST_ACC: axis_r <= 1'b1;
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {7'd0, acc_y_r, acc_x_r, spd_y_r, spd_x_r, ok_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // An invalid sample leaves the displacement untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !(in_flow_ok && in_height_ok)) |=>
      ($stable(acc_x_r) && $stable(acc_y_r)))
    else $error("displacement changed on an invalid sample");

  // The divider never sees a zero interval.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dt_r != 8'd0))
    else $error("divider started with zero interval");

  // The partial remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < dt_r))
    else $error("divider remainder out of range");

  // A result is loaded only from the final state and never overwrites a pending one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_data_r) && out_valid_r))
    else $error("pending result was overwritten");
`endif

endmodule
`default_nettype wire

// File: tb/sv/optical_flow_ground_motion_tb.sv
// ----------------------------------------------------------------------------
// optical_flow_ground_motion_tb
// Self-checking testbench for the optical-flow ground motion block. Samples
// are sent on the input stream. Each accepted sample goes through a local
// model of the velocity and displacement arithmetic, which keeps its own copy
// of the accumulators and registers. Every result transaction is then
// compared field by field with the oldest predicted result. Directed extremes
// and register corner settings come first. Back-pressure and pause tests
// follow, and then randomized phases under varying register settings.
// ----------------------------------------------------------------------------
module optical_flow_ground_motion_tb
  import ofgm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;
  localparam longint MS_PER_S       = 1000;
  localparam longint RATE_ONE       = 4096;
  localparam longint SPEED_MAX      = 64'sd2147483647;
  localparam longint SPEED_MIN      = -64'sd2147483648;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     DRAIN_CYCLES   = 70;
  localparam int     STALL_CYCLES   = 400;

  // One optical-flow sample as carried on in_tdata.
  typedef struct {
    logic               flow_ok;
    logic               height_ok;
    logic [15:0]        agl_mm;
    logic [7:0]         interval_ms;
    logic signed [15:0] flow_angle_x;
    logic signed [15:0] flow_angle_y;
    logic signed [17:0] gyro_pitch;
    logic signed [17:0] gyro_roll;
    logic [1:0]         fill;
  } flow_sample_t;

  // One ground motion result as carried on out_tdata.
  typedef struct {
    logic               motion_ok;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [47:0] travel_x;
    logic signed [47:0] travel_y;
  } ground_motion_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // in_tdata from bit 0: flow_ok, height_ok, agl_mm, interval_ms,
  // flow_angle_x, flow_angle_y, gyro_pitch, gyro_roll, zero fill.
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // out_tdata from bit 0: motion_ok, speed_x, speed_y, travel_x, travel_y,
  // zero fill.
  logic [OUT_W-1:0]  out_tdata;

  // Model state: registers and displacement accumulators.
  logic [15:0] min_height_r;
  logic [7:0]  min_interval_r;
  logic [7:0]  def_interval_r;
  logic [47:0] travel_x_acc;
  logic [47:0] travel_y_acc;

  ground_motion_t pending_motion[$];
  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  int  out_hold = 0;
  bit  in_idle_en = 1'b1;
  bit  out_idle_en = 1'b1;

  optical_flow_ground_motion dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [IN_W-1:0] pack_sample(flow_sample_t s);
    return {s.fill, s.gyro_roll, s.gyro_pitch, s.flow_angle_y, s.flow_angle_x,
            s.interval_ms, s.agl_mm, s.height_ok, s.flow_ok};
  endfunction

  function automatic flow_sample_t unpack_sample(logic [IN_W-1:0] d);
    flow_sample_t s;
    s.flow_ok      = d[0];
    s.height_ok    = d[1];
    s.agl_mm       = d[17:2];
    s.interval_ms  = d[25:18];
    s.flow_angle_x = d[41:26];
    s.flow_angle_y = d[57:42];
    s.gyro_pitch   = d[75:58];
    s.gyro_roll    = d[93:76];
    s.fill         = d[95:94];
    return s;
  endfunction

  function automatic ground_motion_t unpack_motion(logic [OUT_W-1:0] d);
    ground_motion_t m;
    m.motion_ok = d[0];
    m.speed_x   = d[32:1];
    m.speed_y   = d[64:33];
    m.travel_x  = d[112:65];
    m.travel_y  = d[160:113];
    return m;
  endfunction

  // Gyro-compensated rate scaled by height, truncated toward zero and
  // saturated to 32 bits.
  function automatic longint axis_speed(longint angle, longint gyro, longint dt,
                                        longint h);
    longint rate;
    longint v;
    rate = (angle * MS_PER_S) / dt - gyro;
    v = (rate * h) / RATE_ONE;
    if (v > SPEED_MAX) v = SPEED_MAX;
    else if (v < SPEED_MIN) v = SPEED_MIN;
    return v;
  endfunction

  // Expected result of one sample; advances the model accumulators.
  function automatic ground_motion_t predict_motion(flow_sample_t s);
    ground_motion_t m;
    longint h;
    longint dt;
    longint vx;
    longint vy;
    m.motion_ok = s.flow_ok & s.height_ok;
    m.speed_x = '0;
    m.speed_y = '0;
    if (m.motion_ok) begin
      h  = (s.agl_mm < min_height_r) ? min_height_r : s.agl_mm;
      dt = (s.interval_ms <= min_interval_r) ? def_interval_r : s.interval_ms;
      if (dt == 0) dt = 1;
      vx = axis_speed(s.flow_angle_y, s.gyro_pitch, dt, h);
      vy = axis_speed(s.flow_angle_x, s.gyro_roll, dt, h);
      travel_x_acc = travel_x_acc + 48'(vx * dt);
      travel_y_acc = travel_y_acc + 48'(vy * dt);
      m.speed_x = 32'(vx);
      m.speed_y = 32'(vy);
    end
    m.travel_x = travel_x_acc;
    m.travel_y = travel_y_acc;
    return m;
  endfunction

  function automatic void check_value(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Register writes, result checking and prediction, all on the rising edge.
  always @(posedge clk) begin
    ground_motion_t got;
    ground_motion_t want;
    if (!rst_n) begin
      min_height_r   = RST_MIN_HEIGHT;
      min_interval_r = RST_MIN_INTERVAL;
      def_interval_r = RST_DEF_INTERVAL;
      travel_x_acc   = '0;
      travel_y_acc   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_HEIGHT:   min_height_r   = cfg_wdata[15:0];
          REG_MIN_INTERVAL: min_interval_r = cfg_wdata[7:0];
          REG_DEF_INTERVAL: def_interval_r = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = unpack_motion(out_tdata);
        if (pending_motion.size() == 0) begin
          $error("result transaction with no sample pending");
          mismatch_count++;
        end else begin
          want = pending_motion.pop_front();
          check_value("motion_ok", want.motion_ok, got.motion_ok);
          check_value("speed_x", want.speed_x, got.speed_x);
          check_value("speed_y", want.speed_y, got.speed_y);
          check_value("travel_x", want.travel_x, got.travel_x);
          check_value("travel_y", want.travel_y, got.travel_y);
        end
      end
      if (in_tvalid && in_tready)
        pending_motion.push_back(predict_motion(unpack_sample(in_tdata)));
    end
  end

  // Watchdog: ends the run after too long without any transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result receiver: a counted hold-off when requested, else random stalls.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(out_idle_en && ($urandom_range(99) < 18));
    end
  end

  function automatic flow_sample_t make_sample(bit fok, bit hok, logic [15:0] h,
                                               logic [7:0] dt,
                                               logic signed [15:0] ax,
                                               logic signed [15:0] ay,
                                               logic signed [17:0] gp,
                                               logic signed [17:0] gr);
    flow_sample_t s;
    s.flow_ok = fok;
    s.height_ok = hok;
    s.agl_mm = h;
    s.interval_ms = dt;
    s.flow_angle_x = ax;
    s.flow_angle_y = ay;
    s.gyro_pitch = gp;
    s.gyro_roll = gr;
    s.fill = '0;
    return s;
  endfunction

  // Random field value of width w, biased toward zero, extremes and small values.
  function automatic logic [31:0] rand_bits(int unsigned w);
    logic [31:0] mask;
    mask = (32'd1 << w) - 32'd1;
    case ($urandom_range(7))
      0: return '0;
      1: return mask;
      2: return 32'd1 << (w - 1);
      3: return mask >> 1;
      4: return (32'($urandom_range(64)) - 32'd32) & mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic flow_sample_t rand_sample();
    flow_sample_t s;
    if ($urandom_range(99) < 85) begin
      s.flow_ok = 1'b1;
      s.height_ok = 1'b1;
    end else begin
      {s.flow_ok, s.height_ok} = 2'($urandom_range(2));
    end
    s.agl_mm       = 16'(rand_bits(16));
    s.interval_ms  = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'(rand_bits(8));
    s.flow_angle_x = 16'(rand_bits(16));
    s.flow_angle_y = 16'(rand_bits(16));
    s.gyro_pitch   = 18'(rand_bits(18));
    s.gyro_roll    = 18'(rand_bits(18));
    s.fill         = ($urandom_range(15) == 0) ? 2'($urandom) : 2'b00;
    return s;
  endfunction

  // Offers one sample and returns at the edge where it is accepted.
  task automatic send_item(flow_sample_t s);
    @(negedge clk);
    while (in_idle_en && ($urandom_range(99) < 18)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_sample(s);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(int count);
    repeat (count) send_item(rand_sample());
  endtask

  // Stops offering samples and waits until every predicted result has come.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_motion.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Field extremes, both flags and the clamping of height and interval
  // under the reset register values.
  task automatic test_directed();
    flow_sample_t s;
    send_item(make_sample(1, 1, 16'd0, 8'd0, 0, 0, 0, 0));
    send_item(make_sample(0, 1, 16'd5000, 8'd20, 1000, -1000, 500, -500));
    send_item(make_sample(1, 0, 16'd5000, 8'd20, 1000, -1000, 500, -500));
    send_item(make_sample(0, 0, 16'hFFFF, 8'hFF, -32768, 32767, -131072, 131071));
    send_item(make_sample(1, 1, 16'hFFFF, 8'd2, 32767, 32767, -131072, -131072));
    send_item(make_sample(1, 1, 16'hFFFF, 8'd255, -32768, -32768, 131071, 131071));
    send_item(make_sample(1, 1, 16'd99, 8'd1, 12345, -23456, 777, -888));
    send_item(make_sample(1, 1, 16'd100, 8'd2, -32768, 32767, 0, 0));
    // Truncation toward zero for small negative quotients.
    send_item(make_sample(1, 1, 16'd101, 8'd3, -7, -1, 0, 1));
    s = make_sample(1, 1, 16'd2500, 8'd40, -300, 450, -60, 70);
    s.fill = 2'b11;
    send_item(s);
    wait_drained();
  endtask

  // Register corner settings, masking of wide write data and the unused index.
  task automatic test_register_extremes();
    write_reg(REG_MIN_INTERVAL, 16'hA500);
    send_item(make_sample(1, 1, 16'd300, 8'd0, 32767, -32768, 131071, -131072));
    send_item(make_sample(1, 1, 16'hFFFF, 8'd1, -32768, 32767, -131072, 131071));
    wait_drained();
    // Zero default interval falls back to one, and a floor of 255 catches all.
    write_reg(REG_DEF_INTERVAL, 16'hFF00);
    write_reg(REG_MIN_INTERVAL, 16'h12FF);
    send_item(make_sample(1, 1, 16'd1000, 8'd255, 5000, -5000, 100, -100));
    send_item(make_sample(1, 1, 16'd1000, 8'd0, -32768, 32767, 0, 0));
    wait_drained();
    write_reg(REG_DEF_INTERVAL, 16'h5AFF);
    write_reg(REG_MIN_HEIGHT, 16'hFFFF);
    send_item(make_sample(1, 1, 16'd0, 8'd100, 20000, -20000, -131072, 131071));
    send_item(make_sample(1, 1, 16'hFFFF, 8'd7, -1, 1, 0, 0));
    wait_drained();
    write_reg(REG_MIN_HEIGHT, 16'h0000);
    send_item(make_sample(1, 1, 16'd0, 8'd50, 32767, 32767, 131071, 131071));
    wait_drained();
    // A write to the unused index leaves all registers as they are.
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(make_sample(1, 1, 16'd3, 8'd9, -12000, 9000, 4000, -4000));
    wait_drained();
  endtask

  // The receiver holds off while samples keep coming, so the block backs up.
  task automatic test_backpressure();
    write_reg(REG_MIN_HEIGHT, 16'd100);
    write_reg(REG_MIN_INTERVAL, 16'd1);
    write_reg(REG_DEF_INTERVAL, 16'd25);
    @(negedge clk);
    out_hold = STALL_CYCLES;
    in_idle_en = 1'b0;
    send_random(12);
    in_idle_en = 1'b1;
    wait_drained();
  endtask

  // The sender pauses until every result is out, then resumes.
  task automatic test_drain_pause();
    send_random(20);
    wait_drained();
    send_random(20);
    wait_drained();
  endtask

  // Random samples in phases, each under its own register setting.
  task automatic test_random_phases();
    logic [15:0] mh;
    logic [7:0]  mi;
    logic [7:0]  di;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: mh = 16'd0;
        1: mh = 16'hFFFF;
        default: mh = 16'($urandom_range(2000));
      endcase
      case ($urandom_range(4))
        0: mi = 8'd0;
        1: mi = 8'd255;
        default: mi = 8'($urandom_range(40));
      endcase
      di = 8'($urandom_range(1, 255));
      write_reg(REG_MIN_HEIGHT, mh);
      write_reg(REG_MIN_INTERVAL, {8'($urandom), mi});
      write_reg(REG_DEF_INTERVAL, {8'($urandom), di});
      // One phase runs without any idling on either side.
      in_idle_en  = (phase != 3);
      out_idle_en = (phase != 3);
      send_random(95);
      wait_drained();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: optical_flow_ground_motion.f
sv/ofgm_pkg.sv
sv/optical_flow_ground_motion.sv
tb/sv/optical_flow_ground_motion_tb.sv
